>>> src/rce_pkg.sv
// shared types, constants and helpers of the rotor cipher engine
package rce_pkg;

	typedef logic [6:0]  sym_t;
	typedef logic [7:0]  byte_t;
	typedef logic [14:0] seed_t;

	localparam int ALPHA           = 94;
	localparam int ROTOR_COUNT_DEF = 4;
	localparam int KEY_LEN         = 13;
	localparam int KEY_LO_W        = 64;
	localparam int KEY_HI_W        = 40;
	localparam int CFG_IDX_W       = 1;
	localparam int RECIP_SHIFT     = 22;

	localparam logic [15:0] RECIP_MUL  = 16'd44620;
	localparam seed_t       SEED_START = 15'd123;
	localparam logic [3:0]  KEY_LAST   = 4'd12;
	localparam sym_t        SYM_LAST   = 7'd93;
	localparam sym_t        PAIR_LAST  = 7'd92;
	localparam byte_t       LOW_CHAR   = 8'd32;
	localparam byte_t       END_CHAR   = 8'd126;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 1'd1;

	// reduce a value below twice the alphabet size into the alphabet
	function automatic sym_t fold(input byte_t x);
		sym_t r;
		if (x >= byte_t'(ALPHA)) begin
			r = sym_t'(x - byte_t'(ALPHA));
		end else begin
			r = x[6:0];
		end
		return r;
	endfunction

endpackage

>>> src/rce_ifs.sv
// handshake channels of the rotor cipher engine
interface rce_req_if;
	logic          valid;
	logic          ready;
	logic          mode;
	rce_pkg::byte_t char_in;
	logic          line_start;
	modport source (output valid, mode, char_in, line_start, input ready);
	modport sink (input valid, mode, char_in, line_start, output ready);
endinterface

interface rce_rsp_if;
	logic          valid;
	logic          ready;
	rce_pkg::byte_t char_out;
	modport source (output valid, char_out, input ready);
	modport sink (input valid, char_out, output ready);
endinterface

interface rce_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rce_pkg::CFG_IDX_W-1:0]     index;
	logic [rce_pkg::KEY_LO_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/rotor_cipher_engine_top.sv
// rotor cipher engine: rekey sequencer and byte cipher over rotor memories
//
// channels: req takes a word with mode, char_in and line_start; rsp gives
// one word with char_out for every cipher word and none for a rekey word;
// cfg writes key register 0 (key bytes 0..7) or 1 (key bytes 8..12) and is
// always ready. write cfg only while the engine is idle.
// a cipher word of a byte in 32..125 walks the rotor memories one read per
// cycle: ROTOR_COUNT forward reads, one half-rotor read, ROTOR_COUNT inverse
// reads. its result is registered after the last inverse read, and req is
// ready again once that result has moved into the output register.
// a byte outside that range comes back unchanged.
// a rekey word runs the key schedule: 13 seed steps, 94*ROTOR_COUNT fill
// writes, shuffle steps (94 for the vector and 94 per rotor), a swap per
// half-rotor pair (47 pairs) and a write per inverse entry, with no rsp word.
// reset clears the key registers, rotor positions, line position and seed;
// the tables hold nothing usable until the first rekey.
// the result waits in an output register; a stalled rsp holds the next
// result in the engine and req stays low until the register frees.
module rotor_cipher_engine_top #(
	parameter int ROTOR_COUNT = rce_pkg::ROTOR_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rce_req_if.sink    req,
	rce_rsp_if.source  rsp,
	rce_cfg_if.sink    cfg
);

	localparam int ROT_DEPTH = ROTOR_COUNT * rce_pkg::ALPHA;
	localparam int AW        = $clog2(ROT_DEPTH);
	localparam int BW        = $clog2(ROT_DEPTH + 1);
	localparam int JW        = $clog2(ROTOR_COUNT + 1);
	localparam int JIW       = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;

	localparam logic [JW-1:0] J_LAST = JW'(ROTOR_COUNT - 1);
	localparam logic [BW-1:0] B_STEP = BW'(rce_pkg::ALPHA);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SEED  = 5'd1;
	localparam logic [4:0] ST_INIT  = 5'd2;
	localparam logic [4:0] ST_PA    = 5'd3;
	localparam logic [4:0] ST_PB    = 5'd4;
	localparam logic [4:0] ST_PC    = 5'd5;
	localparam logic [4:0] ST_SRD   = 5'd6;
	localparam logic [4:0] ST_SW1   = 5'd7;
	localparam logic [4:0] ST_SW2   = 5'd8;
	localparam logic [4:0] ST_HRD1  = 5'd9;
	localparam logic [4:0] ST_HRD2  = 5'd10;
	localparam logic [4:0] ST_HW1   = 5'd11;
	localparam logic [4:0] ST_HW2   = 5'd12;
	localparam logic [4:0] ST_IRD   = 5'd13;
	localparam logic [4:0] ST_IW    = 5'd14;
	localparam logic [4:0] ST_CFWD  = 5'd15;
	localparam logic [4:0] ST_CHREQ = 5'd16;
	localparam logic [4:0] ST_CHDAT = 5'd17;
	localparam logic [4:0] ST_CINV  = 5'd18;
	localparam logic [4:0] ST_CDONE = 5'd19;

	// state and counters
	logic [4:0]                     state_q;
	logic                           out_valid_q;
	logic [rce_pkg::KEY_LO_W-1:0]   key_lo_q;
	logic [rce_pkg::KEY_HI_W-1:0]   key_hi_q;
	rce_pkg::seed_t                 seed_q;
	rce_pkg::sym_t                  pos_q [ROTOR_COUNT];
	rce_pkg::sym_t                  lp_q;
	rce_pkg::sym_t                  i_q;
	logic [JW-1:0]                  j_q;
	logic [3:0]                     kidx_q;
	logic [BW-1:0]                  base_q;
	logic                           rphase_q;

	// payload registers
	rce_pkg::sym_t                  v_q;
	logic [8:0]                     q_q;
	rce_pkg::sym_t                  k_q;
	rce_pkg::sym_t                  swp_q;
	rce_pkg::sym_t                  ha_q;
	rce_pkg::sym_t                  hb_q;
	rce_pkg::byte_t                 res_q;
	rce_pkg::byte_t                 out_char_q;

	// memories
	rce_pkg::sym_t rot_mem  [ROT_DEPTH];
	rce_pkg::sym_t inv_mem  [ROT_DEPTH];
	rce_pkg::sym_t half_mem [rce_pkg::ALPHA];
	rce_pkg::sym_t sv_mem   [rce_pkg::ALPHA];

	rce_pkg::sym_t rot_rda_q, rot_rdb_q, inv_rd_q;
	rce_pkg::sym_t half_rda_q, half_rdb_q, sv_rda_q, sv_rdb_q;

	logic           rot_we, inv_we, half_we, sv_we;
	logic [AW-1:0]  rot_wa, rot_ra_a, rot_ra_b, inv_wa, inv_ra;
	rce_pkg::sym_t  rot_wd, inv_wd, half_wd, sv_wd;
	rce_pkg::sym_t  half_wa, half_ra_a, half_ra_b, sv_wa, sv_ra_a, sv_ra_b;

	// datapath
	rce_pkg::byte_t key_byte [rce_pkg::KEY_LEN];
	rce_pkg::byte_t kb;
	logic [22:0]    seed_mul;
	rce_pkg::seed_t seed_init_nx;
	logic [17:0]    seed_pick_sum;
	logic [30:0]    recip_prod;
	logic [15:0]    q94;
	logic [15:0]    rem_full;
	rce_pkg::sym_t  pick;
	rce_pkg::sym_t  pos_j;
	rce_pkg::sym_t  fwd_v;
	rce_pkg::sym_t  fwd_idx;
	rce_pkg::sym_t  half_idx;
	rce_pkg::sym_t  half_v;
	rce_pkg::sym_t  inv_v;
	logic [BW-1:0]  base_dn;
	rce_pkg::sym_t  pos_nx [ROTOR_COUNT];
	logic           req_acc;
	logic           in_range;
	logic           out_load;
	logic           rot_tgt;

	always_comb begin
		for (int n = 0; n < rce_pkg::KEY_LEN; n++) begin
			if (n < 8) begin
				key_byte[n] = key_lo_q[8*n +: 8];
			end else begin
				key_byte[n] = key_hi_q[8*(n-8) +: 8];
			end
		end
	end

	assign kb            = key_byte[kidx_q];
	assign seed_mul      = 23'(seed_q) * 23'(kb);
	assign seed_init_nx  = rce_pkg::seed_t'(seed_mul + 23'(kidx_q));
	assign seed_pick_sum = {3'b000, seed_q} + {1'b0, seed_q, 2'b00} + 18'(kb);
	assign recip_prod    = 31'(seed_q) * 31'(rce_pkg::RECIP_MUL);
	assign q94           = 16'(q_q) * 16'(rce_pkg::ALPHA);
	assign rem_full      = 16'(seed_q) - q94;
	assign pick          = rce_pkg::fold(rem_full[7:0]);

	assign pos_j    = pos_q[j_q[JIW-1:0]];
	assign fwd_v    = (j_q == '0) ? v_q : rot_rda_q;
	assign fwd_idx  = rce_pkg::fold({1'b0, fwd_v} + {1'b0, pos_j});
	assign half_idx = rce_pkg::fold({1'b0, rot_rda_q} + {1'b0, lp_q});
	assign half_v   = rce_pkg::fold({1'b0, half_rda_q} +
		(rce_pkg::byte_t'(rce_pkg::ALPHA) - {1'b0, lp_q}));
	assign inv_v    = rce_pkg::fold({1'b0, inv_rd_q} +
		(rce_pkg::byte_t'(rce_pkg::ALPHA) - {1'b0, pos_j}));
	assign base_dn  = base_q - B_STEP;

	assign req_acc  = req.valid && req.ready;
	assign in_range = (req.char_in >= rce_pkg::LOW_CHAR) && (req.char_in < rce_pkg::END_CHAR);
	assign out_load = (state_q == ST_CDONE) && (!out_valid_q || rsp.ready);
	assign rot_tgt  = rphase_q;

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.char_out = out_char_q;
	assign cfg.ready    = 1'b1;

	// odometer step
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int n = 0; n < ROTOR_COUNT; n++) begin
			if (carry) begin
				pos_nx[n] = (pos_q[n] == rce_pkg::SYM_LAST) ? '0 : pos_q[n] + 7'd1;
			end else begin
				pos_nx[n] = pos_q[n];
			end
			carry = carry && (pos_q[n] == rce_pkg::SYM_LAST);
		end
	end

	// memory port control
	always_comb begin
		rot_we    = 1'b0;
		rot_wa    = '0;
		rot_wd    = '0;
		rot_ra_a  = '0;
		rot_ra_b  = '0;
		inv_we    = 1'b0;
		inv_wa    = '0;
		inv_wd    = '0;
		inv_ra    = '0;
		half_we   = 1'b0;
		half_wa   = '0;
		half_wd   = '0;
		half_ra_a = '0;
		half_ra_b = '0;
		sv_we     = 1'b0;
		sv_wa     = '0;
		sv_wd     = '0;
		sv_ra_a   = '0;
		sv_ra_b   = '0;
		case (state_q)
			ST_INIT: begin
				rot_we = 1'b1;
				rot_wa = AW'(base_q + BW'(i_q));
				rot_wd = i_q;
				if (j_q == '0) begin
					half_we = 1'b1;
					half_wa = i_q;
					half_wd = i_q;
					sv_we   = 1'b1;
					sv_wa   = i_q;
					sv_wd   = i_q;
				end
			end
			ST_SRD: begin
				rot_ra_a = AW'(base_q + BW'(i_q));
				rot_ra_b = AW'(base_q + BW'(k_q));
				sv_ra_a  = i_q;
				sv_ra_b  = k_q;
			end
			ST_SW1: begin
				if (rot_tgt) begin
					rot_we = 1'b1;
					rot_wa = AW'(base_q + BW'(i_q));
					rot_wd = rot_rdb_q;
				end else begin
					sv_we = 1'b1;
					sv_wa = i_q;
					sv_wd = sv_rdb_q;
				end
			end
			ST_SW2: begin
				if (rot_tgt) begin
					rot_we = 1'b1;
					rot_wa = AW'(base_q + BW'(k_q));
					rot_wd = swp_q;
				end else begin
					sv_we = 1'b1;
					sv_wa = k_q;
					sv_wd = swp_q;
				end
			end
			ST_HRD1: begin
				sv_ra_a = i_q;
				sv_ra_b = i_q + 7'd1;
			end
			ST_HRD2: begin
				half_ra_a = sv_rda_q;
				half_ra_b = sv_rdb_q;
			end
			ST_HW1: begin
				half_we = 1'b1;
				half_wa = ha_q;
				half_wd = half_rdb_q;
			end
			ST_HW2: begin
				half_we = 1'b1;
				half_wa = hb_q;
				half_wd = swp_q;
			end
			ST_IRD: begin
				rot_ra_a = AW'(base_q + BW'(i_q));
			end
			ST_IW: begin
				inv_we = 1'b1;
				inv_wa = AW'(base_q + BW'(rot_rda_q));
				inv_wd = i_q;
			end
			ST_CFWD: begin
				rot_ra_a = AW'(base_q + BW'(fwd_idx));
			end
			ST_CHREQ: begin
				half_ra_a = half_idx;
			end
			ST_CHDAT: begin
				inv_ra = AW'(base_dn + BW'(half_v));
			end
			ST_CINV: begin
				inv_ra = AW'(base_dn + BW'(inv_v));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rot_we) begin
			rot_mem[rot_wa] <= rot_wd;
		end
		rot_rda_q <= rot_mem[rot_ra_a];
		rot_rdb_q <= rot_mem[rot_ra_b];
	end

	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[inv_wa] <= inv_wd;
		end
		inv_rd_q <= inv_mem[inv_ra];
	end

	always_ff @(posedge clk) begin
		if (half_we) begin
			half_mem[half_wa] <= half_wd;
		end
		half_rda_q <= half_mem[half_ra_a];
		half_rdb_q <= half_mem[half_ra_b];
	end

	always_ff @(posedge clk) begin
		if (sv_we) begin
			sv_mem[sv_wa] <= sv_wd;
		end
		sv_rda_q <= sv_mem[sv_ra_a];
		sv_rdb_q <= sv_mem[sv_ra_b];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			key_lo_q    <= '0;
			key_hi_q    <= '0;
			seed_q      <= '0;
			lp_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			kidx_q      <= '0;
			base_q      <= '0;
			rphase_q    <= 1'b0;
			for (int n = 0; n < ROTOR_COUNT; n++) begin
				pos_q[n] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					rce_pkg::REG_KEY_LO: key_lo_q <= cfg.data;
					rce_pkg::REG_KEY_HI: key_hi_q <= cfg.data[rce_pkg::KEY_HI_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.line_start) begin
							lp_q <= '0;
						end
						if (!req.mode) begin
							seed_q <= rce_pkg::SEED_START;
							kidx_q <= '0;
							for (int n = 0; n < ROTOR_COUNT; n++) begin
								pos_q[n] <= '0;
							end
							state_q <= ST_SEED;
						end else if (in_range) begin
							j_q     <= '0;
							base_q  <= '0;
							state_q <= ST_CFWD;
						end else begin
							state_q <= ST_CDONE;
						end
					end
				end
				ST_SEED: begin
					seed_q <= seed_init_nx;
					if (kidx_q == rce_pkg::KEY_LAST) begin
						kidx_q  <= '0;
						i_q     <= '0;
						j_q     <= '0;
						base_q  <= '0;
						state_q <= ST_INIT;
					end else begin
						kidx_q <= kidx_q + 4'd1;
					end
				end
				ST_INIT: begin
					if (i_q == rce_pkg::SYM_LAST) begin
						i_q <= '0;
						if (j_q == J_LAST) begin
							j_q      <= '0;
							base_q   <= '0;
							rphase_q <= 1'b0;
							state_q  <= ST_PA;
						end else begin
							j_q    <= j_q + JW'(1);
							base_q <= base_q + B_STEP;
						end
					end else begin
						i_q <= i_q + 7'd1;
					end
				end
				ST_PA: begin
					seed_q  <= seed_pick_sum[14:0];
					kidx_q  <= (kidx_q == rce_pkg::KEY_LAST) ? 4'd0 : kidx_q + 4'd1;
					state_q <= ST_PB;
				end
				ST_PB: state_q <= ST_PC;
				ST_PC: state_q <= ST_SRD;
				ST_SRD: state_q <= ST_SW1;
				ST_SW1: state_q <= ST_SW2;
				ST_SW2: begin
					if (i_q == rce_pkg::SYM_LAST) begin
						i_q     <= '0;
						state_q <= rphase_q ? ST_IRD : ST_HRD1;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= ST_PA;
					end
				end
				ST_HRD1: state_q <= ST_HRD2;
				ST_HRD2: state_q <= ST_HW1;
				ST_HW1: state_q <= ST_HW2;
				ST_HW2: begin
					if (i_q == rce_pkg::PAIR_LAST) begin
						i_q      <= '0;
						kidx_q   <= '0;
						j_q      <= '0;
						base_q   <= '0;
						rphase_q <= 1'b1;
						state_q  <= ST_PA;
					end else begin
						i_q     <= i_q + 7'd2;
						state_q <= ST_HRD1;
					end
				end
				ST_IRD: state_q <= ST_IW;
				ST_IW: begin
					if (i_q == rce_pkg::SYM_LAST) begin
						i_q <= '0;
						if (j_q == J_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + JW'(1);
							base_q  <= base_q + B_STEP;
							kidx_q  <= '0;
							state_q <= ST_PA;
						end
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= ST_IRD;
					end
				end
				ST_CFWD: begin
					j_q    <= j_q + JW'(1);
					base_q <= base_q + B_STEP;
					if (j_q == J_LAST) begin
						state_q <= ST_CHREQ;
					end
				end
				ST_CHREQ: state_q <= ST_CHDAT;
				ST_CHDAT: begin
					j_q     <= J_LAST;
					base_q  <= base_dn;
					state_q <= ST_CINV;
				end
				ST_CINV: begin
					if (j_q == '0) begin
						for (int n = 0; n < ROTOR_COUNT; n++) begin
							pos_q[n] <= pos_nx[n];
						end
						lp_q    <= (lp_q == rce_pkg::SYM_LAST) ? '0 : lp_q + 7'd1;
						state_q <= ST_CDONE;
					end else begin
						j_q    <= j_q - JW'(1);
						base_q <= base_dn;
					end
				end
				ST_CDONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q   <= rce_pkg::sym_t'(req.char_in - rce_pkg::LOW_CHAR);
				res_q <= req.char_in;
			end
			ST_PB: q_q <= 9'(recip_prod >> rce_pkg::RECIP_SHIFT);
			ST_PC: k_q <= pick;
			ST_SW1: swp_q <= rot_tgt ? rot_rda_q : sv_rda_q;
			ST_HRD2: begin
				ha_q <= sv_rda_q;
				hb_q <= sv_rdb_q;
			end
			ST_HW1: swp_q <= half_rda_q;
			ST_CINV: begin
				if (j_q == '0) begin
					res_q <= {1'b0, inv_v} + rce_pkg::LOW_CHAR;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_char_q <= res_q;
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench of the rotor cipher engine: directed table, then keyed random messages, checked against a predictor
module testbench;

	localparam int NROT          = rce_pkg::ROTOR_COUNT_DEF;
	localparam int SEED_MOD      = 65521;
	localparam int SEED_MASK     = 'h7fff;
	localparam int SETTLE_CYCLES = 5000;
	localparam int QUIET_LIMIT   = 40000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_WORDS   = 200;
	localparam int PHASES        = 4;
	localparam int N_DIRECTED    = 20;

	localparam logic MODE_REKEY  = 1'b0;
	localparam logic MODE_CIPHER = 1'b1;

	localparam int SEND_IDLE  [PHASES] = '{0, 60, 0, 37};
	localparam int RECV_STALL [PHASES] = '{0, 0, 60, 37};

	typedef struct packed {
		logic           mode;
		rce_pkg::byte_t char_in;
		logic           line_start;
		logic           known;
		rce_pkg::byte_t char_out;
	} stim_row_t;

	typedef struct packed {
		logic           known;
		rce_pkg::byte_t val;
	} tag_t;

	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{MODE_REKEY,  8'd0,   1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd32,  1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd125, 1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd0,   1'b0, 1'b1, 8'd0},
		'{MODE_CIPHER, 8'd31,  1'b0, 1'b1, 8'd31},
		'{MODE_CIPHER, 8'd126, 1'b0, 1'b1, 8'd126},
		'{MODE_CIPHER, 8'd255, 1'b0, 1'b1, 8'd255},
		'{MODE_CIPHER, 8'd128, 1'b0, 1'b1, 8'd128},
		'{MODE_CIPHER, 8'd65,  1'b1, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd66,  1'b0, 1'b0, 8'd0},
		'{MODE_REKEY,  8'd255, 1'b1, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd85,  1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd106, 1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd42,  1'b1, 1'b0, 8'd0},
		'{MODE_REKEY,  8'd77,  1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd65,  1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd124, 1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd127, 1'b1, 1'b1, 8'd127},
		'{MODE_CIPHER, 8'd33,  1'b0, 1'b0, 8'd0},
		'{MODE_CIPHER, 8'd65,  1'b0, 1'b0, 8'd0}
	};

	logic clk;
	logic arst_n;

	rce_req_if req ();
	rce_rsp_if rsp ();
	rce_cfg_if cfg ();

	rotor_cipher_engine_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// cipher state as the engine should hold it
	rce_pkg::sym_t                rotor_map [NROT][rce_pkg::ALPHA];
	rce_pkg::sym_t                rotor_inv [NROT][rce_pkg::ALPHA];
	rce_pkg::sym_t                reflector [rce_pkg::ALPHA];
	rce_pkg::sym_t                scramble  [rce_pkg::ALPHA];
	int unsigned                  step_pos  [NROT] = '{default: 0};
	int unsigned                  line_pos = 0;
	int unsigned                  seed_now = 0;
	logic [rce_pkg::KEY_LO_W-1:0] key_lo = '0;
	logic [rce_pkg::KEY_HI_W-1:0] key_hi = '0;

	rce_pkg::byte_t expected_bytes [$];
	tag_t           tag_q [$];
	int             mismatches = 0;
	int             results_seen = 0;
	int             quiet_cycles = 0;
	int             cur_phase = -1;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	bit             held_once = 1'b0;

	function automatic int unsigned key_byte_at(int unsigned n);
		int unsigned k;
		k = n % rce_pkg::KEY_LEN;
		if (k < 8) return key_lo[8*k +: 8];
		return key_hi[8*(k-8) +: 8];
	endfunction

	function automatic int unsigned draw_index(int unsigned n);
		seed_now = (5 * seed_now + key_byte_at(n)) & SEED_MASK;
		return ((seed_now % SEED_MOD) & SEED_MASK) % rce_pkg::ALPHA;
	endfunction

	function automatic void rebuild_rotors();
		int unsigned   k;
		int            a;
		int            b;
		rce_pkg::sym_t t;
		for (int j = 0; j < NROT; j++) begin
			step_pos[j] = 0;
			for (int i = 0; i < rce_pkg::ALPHA; i++) rotor_map[j][i] = rce_pkg::sym_t'(i);
		end
		seed_now = rce_pkg::SEED_START;
		for (int i = 0; i < rce_pkg::KEY_LEN; i++)
			seed_now = (seed_now * key_byte_at(i) + i) & SEED_MASK;
		for (int i = 0; i < rce_pkg::ALPHA; i++) begin
			reflector[i] = rce_pkg::sym_t'(i);
			scramble[i]  = rce_pkg::sym_t'(i);
		end
		for (int i = 0; i < rce_pkg::ALPHA; i++) begin
			k = draw_index(i);
			t = scramble[k];
			scramble[k] = scramble[i];
			scramble[i] = t;
		end
		for (int i = 0; i + 1 < rce_pkg::ALPHA; i += 2) begin
			a = scramble[i] % rce_pkg::ALPHA;
			b = scramble[i+1] % rce_pkg::ALPHA;
			t = reflector[a];
			reflector[a] = reflector[b];
			reflector[b] = t;
		end
		for (int j = 0; j < NROT; j++) begin
			for (int i = 0; i < rce_pkg::ALPHA; i++) begin
				k = draw_index(i);
				t = rotor_map[j][i];
				rotor_map[j][i] = rotor_map[j][k];
				rotor_map[j][k] = t;
			end
			for (int i = 0; i < rce_pkg::ALPHA; i++)
				rotor_inv[j][rotor_map[j][i] % rce_pkg::ALPHA] = rce_pkg::sym_t'(i);
		end
	endfunction

	function automatic rce_pkg::byte_t encode_byte(rce_pkg::byte_t c);
		int unsigned v;
		int unsigned lp;
		int          j;
		if (c < rce_pkg::LOW_CHAR || c >= rce_pkg::LOW_CHAR + rce_pkg::ALPHA) return c;
		v  = c - rce_pkg::LOW_CHAR;
		lp = line_pos % rce_pkg::ALPHA;
		for (j = 0; j < NROT; j++)
			v = rotor_map[j][(v + step_pos[j]) % rce_pkg::ALPHA] % rce_pkg::ALPHA;
		v = (reflector[(v + lp) % rce_pkg::ALPHA] % rce_pkg::ALPHA + rce_pkg::ALPHA - lp)
			% rce_pkg::ALPHA;
		for (j = NROT - 1; j >= 0; j--)
			v = (rotor_inv[j][v] % rce_pkg::ALPHA + rce_pkg::ALPHA - step_pos[j])
				% rce_pkg::ALPHA;
		// odometer step
		j = 0;
		step_pos[0]++;
		while (step_pos[j] >= rce_pkg::ALPHA) begin
			step_pos[j] = 0;
			j++;
			if (j == NROT) break;
			step_pos[j]++;
		end
		line_pos = (lp + 1) % rce_pkg::ALPHA;
		return rce_pkg::byte_t'(v + rce_pkg::LOW_CHAR);
	endfunction

	always @(posedge clk) begin : edge_monitor
		tag_t           tag;
		rce_pkg::byte_t want;
		if (rsp.valid && rsp.ready) begin
			results_seen++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t unexpected char_out: expected none, actual %0d", $time, rsp.char_out);
			end else begin
				want = expected_bytes.pop_front();
				if (rsp.char_out !== want) begin
					mismatches++;
					$display("%0t char_out mismatch: expected %0d, actual %0d", $time, want,
						rsp.char_out);
				end
			end
		end
		if (req.valid && req.ready) begin
			tag = tag_q.pop_front();
			if (req.line_start) line_pos = 0;
			if (req.mode == MODE_REKEY) begin
				rebuild_rotors();
			end else begin
				want = encode_byte(req.char_in);
				expected_bytes.push_back(tag.known ? tag.val : want);
			end
		end
		if (cfg.valid && cfg.ready) begin
			if (cfg.index == rce_pkg::REG_KEY_LO) key_lo = cfg.data;
			else key_hi = cfg.data[rce_pkg::KEY_HI_W-1:0];
		end
		if ((rsp.valid && rsp.ready) || (req.valid && req.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t timeout: no word accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side, with one long hold-off in phase 0, the phase without idling or stalls
	initial begin : result_drain
		int hold_left;
		hold_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (cur_phase == 0 && !held_once && results_seen >= 60) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_word(logic mode, rce_pkg::byte_t ch, logic ls, logic known,
		rce_pkg::byte_t typed_out);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		tag_q.push_back({known, typed_out});
		req.valid      <= 1'b1;
		req.mode       <= mode;
		req.char_in    <= ch;
		req.line_start <= ls;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic write_key(logic [rce_pkg::CFG_IDX_W-1:0] idx,
		logic [rce_pkg::KEY_LO_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic settle();
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// messages: a rekey first, then groups of lines that mostly open with a line start, often after another rekey
	task automatic run_messages(int words);
		int             sent;
		int             lines;
		int             len;
		rce_pkg::byte_t ch;
		logic           ls;
		sent = 0;
		while (sent < words) begin
			if (sent == 0 || $urandom_range(2) != 0) begin
				send_word(MODE_REKEY, rce_pkg::byte_t'($urandom), 1'($urandom_range(1)), 1'b0,
					'0);
				sent++;
			end
			lines = $urandom_range(3, 1);
			repeat (lines) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(5, 1) : $urandom_range(130, 20);
				for (int i = 0; i < len && sent < words; i++) begin
					ls = ((i == 0) && ($urandom_range(3) != 0)) || ($urandom_range(63) == 0);
					if ($urandom_range(99) < 85) ch = rce_pkg::byte_t'($urandom_range(125, 32));
					else ch = rce_pkg::byte_t'($urandom);
					send_word(MODE_CIPHER, ch, ls, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [rce_pkg::KEY_LO_W-1:0] lo;
		logic [rce_pkg::KEY_LO_W-1:0] hi;
		req.valid      <= 1'b0;
		req.mode       <= MODE_REKEY;
		req.char_in    <= '0;
		req.line_start <= 1'b0;
		cfg.valid      <= 1'b0;
		cfg.index      <= rce_pkg::REG_KEY_LO;
		cfg.data       <= '0;
		arst_n         <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++)
			send_word(DIRECTED[r].mode, DIRECTED[r].char_in, DIRECTED[r].line_start,
				DIRECTED[r].known, DIRECTED[r].char_out);

		for (int p = 0; p < PHASES; p++) begin
			req.valid <= 1'b0;
			settle();
			case (p)
				0: begin
					lo = '1;
					hi = {24'd0, 40'hff_ffff_ffff};
				end
				1: begin
					lo = {$urandom, $urandom};
					hi = {24'd0, 8'($urandom), 32'($urandom)};
				end
				2: begin
					lo = '0;
					hi = {24'd0, 8'($urandom), 32'($urandom)};
				end
				default: begin
					lo = {$urandom, $urandom};
					hi = '0;
				end
			endcase
			write_key(rce_pkg::REG_KEY_LO, lo);
			write_key(rce_pkg::REG_KEY_HI, hi);
			cfg.valid <= 1'b0;
			cur_phase      = p;
			send_idle_pct  = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			run_messages(PHASE_WORDS);
		end

		req.valid <= 1'b0;
		settle();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
